### hdl/cccd_pkg.sv
// Shared types, codes and the byte-wide CRC-32 step for the chunk deframer.
`timescale 1ns / 1ps

package cccd_pkg;

    localparam int unsigned CfgIdxW = 4;
    localparam int unsigned CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] REG_MAGIC_FIRST = 4'd0;
    localparam logic [CfgIdxW-1:0] REG_MAGIC_SECOND = 4'd1;
    localparam logic [CfgIdxW-1:0] REG_MAX_PAYLOAD_LEN = 4'd2;
    localparam logic [CfgIdxW-1:0] REG_ACK_INTERVAL = 4'd3;

    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_GOOD = 3'd1;
    localparam logic [2:0] KIND_BAD_LEN = 3'd2;
    localparam logic [2:0] KIND_CRC_BAD = 3'd3;
    localparam logic [2:0] KIND_ARMED = 3'd4;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_BEGIN = 1'b1;

    localparam logic [16:0] HDR_BYTES = 17'd4;
    localparam logic [16:0] CRC_BYTES = 17'd4;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        mode;
        logic [7:0]  rx_byte;
        logic [31:0] image_size;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic        ack_due;
        logic        image_complete;
        logic [31:0] bytes_done;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  magic_first;
        logic [7:0]  magic_second;
        logic [15:0] max_payload_len;
        logic [7:0]  ack_interval;
    } cfg_t;

    typedef struct packed {
        logic armed;
        logic hunting;
    } status_t;

    // Reflected CRC-32, one byte folded in; flattens to an XOR network.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hdl/crc_checked_chunk_deframer_top.sv
// Top level of the magic/length/payload/CRC-32 chunk deframer.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------
//  item     | in        | item_valid / item_stall | item_data   (in_item_t)
//  result   | out       | result_valid / _stall   | result_data (out_item_t)
//  cfg      | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item per cycle is taken while item_stall is low; each result is registered.
// The byte-wide CRC-32 step and the 33-bit written-count add set the cycle path.
// Up to two results are held (result register plus skid); item_stall is raised
// only while the skid entry is occupied. Reset clears state and counters and loads
// config defaults. Config writes are always ready and take effect at the next edge.
`timescale 1ns / 1ps

module crc_checked_chunk_deframer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  cccd_pkg::in_item_t            item_data,
    output logic                          result_valid,
    input  logic                          result_stall,
    output cccd_pkg::out_item_t           result_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cccd_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [cccd_pkg::CfgDataW-1:0] cfg_data
);
    import cccd_pkg::*;

    cfg_t      cfg;
    status_t   status;
    logic      step;
    logic      res_valid;
    out_item_t res;
    logic      buf_full;

    assign cfg_ready = 1'b1;
    assign item_stall = buf_full;
    assign step = item_valid && !buf_full;

    cccd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cccd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item_data),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    cccd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (result_data)
    );

    // Skid entry is only ever filled behind a held result.
    a_skid_behind_result: assert property (@(posedge clk) disable iff (!rst_n)
        buf_full |-> result_valid)
        else $error("skid entry occupied with no result pending");

    // Disarmed parser always waits for a first magic byte.
    a_disarmed_hunting: assert property (@(posedge clk) disable iff (!rst_n)
        !status.armed |-> status.hunting)
        else $error("parser position not cleared while disarmed");

    // A begin transaction leaves the parser armed and hunting for a first magic byte.
    a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item_data.mode == MODE_BEGIN) |=> !status.hunting == 1'b0 && status.armed)
        else $error("begin did not arm and reset the parser");

    // Only a good frame may flag an ack or completion.
    a_flags_on_good: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.kind != KIND_GOOD)
            |-> (!result_data.ack_due && !result_data.image_complete))
        else $error("ack or complete flag on a non-frame result");

endmodule

### hdl/cccd_cfg.sv
// Configuration register file of the chunk deframer.
`timescale 1ns / 1ps

module cccd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [cccd_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [cccd_pkg::CfgDataW-1:0] cfg_data,
    output cccd_pkg::cfg_t                cfg
);
    import cccd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAGIC_FIRST:     cfg_next.magic_first = cfg_data[7:0];
                REG_MAGIC_SECOND:    cfg_next.magic_second = cfg_data[7:0];
                REG_MAX_PAYLOAD_LEN: cfg_next.max_payload_len = cfg_data;
                REG_ACK_INTERVAL:    cfg_next.ack_interval = cfg_data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_first <= 8'd0;
            cfg_reg.magic_second <= 8'd0;
            cfg_reg.max_payload_len <= 16'd1024;
            cfg_reg.ack_interval <= 8'd8;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/cccd_parser.sv
// Frame parser, CRC accumulator and write counters; one byte per transaction.
`timescale 1ns / 1ps

module cccd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  cccd_pkg::in_item_t  item,
    input  cccd_pkg::cfg_t      cfg,
    output logic                res_valid,
    output cccd_pkg::out_item_t res,
    output cccd_pkg::status_t   status
);
    import cccd_pkg::*;

    logic        armed_reg, armed_next;
    logic [16:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] rcv_reg, rcv_next;
    logic [31:0] written_reg, written_next;
    logic [7:0]  since_ack_reg, since_ack_next;
    logic [31:0] target_reg, target_next;

    logic [7:0]  b;
    logic [15:0] len_full;
    logic [16:0] payload_end;
    logic [16:0] pos_inc;
    logic [31:0] rcv_shift;
    logic [32:0] sum;
    logic [31:0] written_sat;
    logic [7:0]  since_inc;
    logic        complete;

    assign b = item.rx_byte;
    assign len_full = {len_reg[15:8], b};
    assign payload_end = HDR_BYTES + {1'b0, len_reg};
    assign pos_inc = pos_reg + 17'd1;
    assign rcv_shift = {rcv_reg[23:0], b};
    assign sum = {1'b0, written_reg} + {17'd0, len_reg};
    assign written_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign since_inc = since_ack_reg + 8'd1;
    assign complete = written_sat >= target_reg;

    always_comb
    begin
        armed_next = armed_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        crc_next = crc_reg;
        rcv_next = rcv_reg;
        written_next = written_reg;
        since_ack_next = since_ack_reg;
        target_next = target_reg;
        res_valid = 1'b0;
        res.kind = KIND_PAYLOAD;
        res.payload_byte = 8'd0;
        res.ack_due = 1'b0;
        res.image_complete = 1'b0;

        if (step)
        begin
            if (item.mode == MODE_BEGIN)
            begin
                armed_next = 1'b1;
                pos_next = 17'd0;
                len_next = 16'd0;
                crc_next = CRC_INIT;
                rcv_next = 32'd0;
                written_next = 32'd0;
                since_ack_next = 8'd0;
                target_next = item.image_size;
                res_valid = 1'b1;
                res.kind = KIND_ARMED;
            end
            else if (armed_reg)
            begin
                if (pos_reg == 17'd0)
                begin
                    if (b == cfg.magic_first)
                        pos_next = 17'd1;
                end
                else if (pos_reg == 17'd1)
                begin
                    // Resync: a repeated first magic byte may start a new frame.
                    if (b == cfg.magic_second)
                        pos_next = 17'd2;
                    else if (b == cfg.magic_first)
                        pos_next = 17'd1;
                    else
                        pos_next = 17'd0;
                end
                else if (pos_reg == 17'd2)
                begin
                    len_next = {b, 8'd0};
                    pos_next = 17'd3;
                end
                else if (pos_reg == 17'd3)
                begin
                    len_next = len_full;
                    if (len_full == 16'd0 || len_full > cfg.max_payload_len)
                    begin
                        armed_next = 1'b0;
                        pos_next = 17'd0;
                        res_valid = 1'b1;
                        res.kind = KIND_BAD_LEN;
                    end
                    else
                    begin
                        crc_next = CRC_INIT;
                        rcv_next = 32'd0;
                        pos_next = HDR_BYTES;
                    end
                end
                else if (pos_reg < payload_end)
                begin
                    crc_next = crc32_byte(crc_reg, b);
                    pos_next = pos_inc;
                    res_valid = 1'b1;
                    res.kind = KIND_PAYLOAD;
                    res.payload_byte = b;
                end
                else
                begin
                    rcv_next = rcv_shift;
                    pos_next = pos_inc;
                    if (pos_inc == payload_end + CRC_BYTES)
                    begin
                        pos_next = 17'd0;
                        res_valid = 1'b1;
                        if (rcv_shift != ~crc_reg)
                        begin
                            armed_next = 1'b0;
                            res.kind = KIND_CRC_BAD;
                        end
                        else
                        begin
                            written_next = written_sat;
                            since_ack_next = since_inc;
                            res.kind = KIND_GOOD;
                            res.image_complete = complete;
                            if (complete || since_inc >= cfg.ack_interval)
                            begin
                                res.ack_due = 1'b1;
                                since_ack_next = 8'd0;
                            end
                            if (complete)
                                armed_next = 1'b0;
                        end
                    end
                end
            end
        end
        res.bytes_done = written_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            pos_reg <= 17'd0;
            len_reg <= 16'd0;
            crc_reg <= CRC_INIT;
            rcv_reg <= 32'd0;
            written_reg <= 32'd0;
            since_ack_reg <= 8'd0;
            target_reg <= 32'd0;
        end
        else
        begin
            armed_reg <= armed_next;
            pos_reg <= pos_next;
            len_reg <= len_next;
            crc_reg <= crc_next;
            rcv_reg <= rcv_next;
            written_reg <= written_next;
            since_ack_reg <= since_ack_next;
            target_reg <= target_next;
        end
    end

    assign status.armed = armed_reg;
    assign status.hunting = (pos_reg == 17'd0);

endmodule

### hdl/cccd_outbuf.sv
// Result register with one skid entry, so a waiting result does not block input.
`timescale 1ns / 1ps

module cccd_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cccd_pkg::out_item_t push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output cccd_pkg::out_item_t out_data
);
    import cccd_pkg::*;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_data_reg, out_data_next;
    out_item_t skid_data_reg, skid_data_next;
    logic      take;

    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next = out_data_reg;
        skid_data_next = skid_data_reg;
        if (skid_valid_reg)
        begin
            // Input is held off; drain skid into the result register.
            if (take)
            begin
                out_data_next = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
            begin
                skid_data_next = push_data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_data_next = push_data;
                out_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

### sim/tb_crc_checked_chunk_deframer_top.sv
// Self-checking testbench for the CRC-checked chunk deframer top level.
`timescale 1ns / 1ps

module tb_crc_checked_chunk_deframer_top;
    import cccd_pkg::*;

    class deframer_scoreboard;
        logic [7:0]  magic_a;
        logic [7:0]  magic_b;
        logic [15:0] len_limit;
        logic [7:0]  ack_every;

        bit          armed;
        int unsigned pos;
        logic [15:0] flen;
        logic [31:0] crc_run;
        logic [31:0] crc_seen;
        logic [31:0] written;
        logic [7:0]  good_since_ack;
        logic [31:0] target;

        out_item_t   pending_events[$];
        int unsigned mismatches;

        function new();
            magic_a = 8'h00;
            magic_b = 8'h00;
            len_limit = 16'd1024;
            ack_every = 8'd8;
            armed = 1'b0;
            pos = 0;
            flen = '0;
            crc_run = CRC_INIT;
            crc_seen = '0;
            written = '0;
            good_since_ack = '0;
            target = '0;
            mismatches = 0;
        endfunction

        // Reflected CRC-32, one data bit at a time, LSB first.
        static function logic [31:0] crc_fold(logic [31:0] acc, logic [7:0] data);
            logic [31:0] c;
            c = acc;
            for (int k = 0; k < 8; k++)
            begin
                if (c[0] ^ data[k])
                    c = (c >> 1) ^ CRC_POLY;
                else
                    c = c >> 1;
            end
            return c;
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                REG_MAGIC_FIRST: magic_a = val[7:0];
                REG_MAGIC_SECOND: magic_b = val[7:0];
                REG_MAX_PAYLOAD_LEN: len_limit = val;
                REG_ACK_INTERVAL: ack_every = val[7:0];
                default: ;
            endcase
        endfunction

        // Advance the frame parser by one accepted transaction; returns 0 if it is ignored.
        function bit take_item(in_item_t it);
            out_item_t   ev;
            logic [32:0] sum;
            bit          complete;
            ev = '0;
            if (it.mode == MODE_BEGIN)
            begin
                armed = 1'b1;
                pos = 0;
                flen = '0;
                crc_run = CRC_INIT;
                crc_seen = '0;
                written = '0;
                good_since_ack = '0;
                target = it.image_size;
                ev.kind = KIND_ARMED;
                pending_events.push_back(ev);
                return 1'b1;
            end
            if (!armed)
                return 1'b0;
            ev.bytes_done = written;
            if (pos == 0)
            begin
                if (it.rx_byte == magic_a)
                    pos = 1;
            end
            else if (pos == 1)
            begin
                if (it.rx_byte == magic_b)
                    pos = 2;
                else if (it.rx_byte == magic_a)
                    pos = 1;
                else
                    pos = 0;
            end
            else if (pos == 2)
            begin
                flen = {it.rx_byte, 8'h00};
                pos = 3;
            end
            else if (pos == 3)
            begin
                flen[7:0] = it.rx_byte;
                if (flen == 16'd0 || flen > len_limit)
                begin
                    armed = 1'b0;
                    pos = 0;
                    ev.kind = KIND_BAD_LEN;
                    pending_events.push_back(ev);
                end
                else
                begin
                    crc_run = CRC_INIT;
                    crc_seen = '0;
                    pos = 32'(HDR_BYTES);
                end
            end
            else if (pos < HDR_BYTES + flen)
            begin
                crc_run = crc_fold(crc_run, it.rx_byte);
                pos++;
                ev.kind = KIND_PAYLOAD;
                ev.payload_byte = it.rx_byte;
                pending_events.push_back(ev);
            end
            else
            begin
                crc_seen = {crc_seen[23:0], it.rx_byte};
                pos++;
                if (pos == HDR_BYTES + CRC_BYTES + flen)
                begin
                    pos = 0;
                    if (crc_seen != ~crc_run)
                    begin
                        armed = 1'b0;
                        ev.kind = KIND_CRC_BAD;
                    end
                    else
                    begin
                        // saturate the byte count instead of wrapping
                        sum = {1'b0, written} + 33'(flen);
                        written = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        good_since_ack++;
                        complete = (written >= target);
                        ev.kind = KIND_GOOD;
                        ev.image_complete = complete;
                        ev.bytes_done = written;
                        if (complete || good_since_ack >= ack_every)
                        begin
                            ev.ack_due = 1'b1;
                            good_since_ack = '0;
                        end
                        if (complete)
                            armed = 1'b0;
                    end
                    pending_events.push_back(ev);
                end
            end
            return 1'b1;
        endfunction

        function void match_event(out_item_t got);
            out_item_t want;
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind=%0d byte=%02h ack=%0b complete=%0b done=%0d",
                             got.kind, got.payload_byte, got.ack_due, got.image_complete,
                             got.bytes_done);
                return;
            end
            want = pending_events.pop_front();
            if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                got.ack_due !== want.ack_due || got.image_complete !== want.image_complete ||
                got.bytes_done !== want.bytes_done)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected kind=%0d byte=%02h ack=%0b complete=%0b ",
                              "done=%0d, got kind=%0d byte=%02h ack=%0b complete=%0b done=%0d"},
                             want.kind, want.payload_byte, want.ack_due, want.image_complete,
                             want.bytes_done, got.kind, got.payload_byte, got.ack_due,
                             got.image_complete, got.bytes_done);
            end
        endfunction
    endclass

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 250;
    localparam int unsigned SETTLE_CYCLES = 4;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    in_item_t            item_data;
    logic                result_valid;
    logic                result_stall;
    out_item_t           result_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    deframer_scoreboard sb = new();
    bit                 brisk = 1'b0;
    bit                 hold_req = 1'b0;
    int unsigned        live_items = 0;

    crc_checked_chunk_deframer_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item_data(item_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hold valid high across back-to-back transactions; lower it only for a gap.
    task automatic offer(in_item_t it);
        int unsigned gap;
        gap = brisk ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data <= it;
        do
            @(posedge clk);
        while (item_stall);
        if (sb.take_item(it))
            live_items++;
    endtask

    task automatic send_byte(logic [7:0] b);
        in_item_t it;
        it.mode = MODE_BYTE;
        it.rx_byte = b;
        it.image_size = $urandom();
        offer(it);
    endtask

    task automatic send_begin(logic [31:0] size);
        in_item_t it;
        it.mode = MODE_BEGIN;
        it.rx_byte = 8'($urandom());
        it.image_size = size;
        offer(it);
    endtask

    task automatic send_header(logic [15:0] len);
        send_byte(sb.magic_a);
        send_byte(sb.magic_b);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_frame(logic [15:0] len, bit mangle);
        logic [31:0] crc;
        logic [7:0]  b;
        crc = CRC_INIT;
        send_header(len);
        for (int n = 0; n < len; n++)
        begin
            b = 8'($urandom());
            crc = sb.crc_fold(crc, b);
            send_byte(b);
        end
        crc = ~crc;
        if (mangle)
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        for (int n = 3; n >= 0; n--)
            send_byte(crc[8*n +: 8]);
    endtask

    task automatic send_bad_header();
        int unsigned lim;
        lim = 32'(sb.len_limit);
        if (lim == 32'h0000_FFFF || $urandom_range(0, 2) == 0)
            send_header(16'h0000);
        else
            send_header(16'($urandom_range(lim + 1, 32'h0000_FFFF)));
    endtask

    function automatic logic [15:0] pick_len();
        int unsigned cap;
        cap = ($urandom_range(0, 24) == 0) ? 300 : 12;
        if (cap > sb.len_limit)
            cap = 32'(sb.len_limit);
        return 16'($urandom_range(1, cap));
    endfunction

    function automatic logic [31:0] pick_size();
        int unsigned sel;
        sel = $urandom_range(0, 3);
        if (sel < 2)
            return $urandom_range(0, 80);
        else if (sel == 2)
            return $urandom();
        else
            return 32'hFFFF_FFFF;
    endfunction

    // Drop valid, wait until every expected result is in, then let the block go idle.
    task automatic settle();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reconfigure(logic [7:0] m1, logic [7:0] m2, logic [15:0] lim,
                               logic [7:0] ack);
        logic [CfgIdxW-1:0]  idx[4];
        logic [CfgDataW-1:0] val[4];
        idx = '{REG_MAGIC_FIRST, REG_MAGIC_SECOND, REG_MAX_PAYLOAD_LEN, REG_ACK_INTERVAL};
        val = '{{8'h00, m1}, {8'h00, m2}, lim, {8'h00, ack}};
        settle();
        for (int n = 0; n < 4; n++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[n];
            cfg_data <= val[n];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_reg(idx[n], val[n]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, plus broken frames and noise.
    task automatic random_stream(int unsigned quota);
        int unsigned start;
        int unsigned pick;
        int unsigned b;
        start = live_items;
        while (live_items - start < quota)
        begin
            brisk = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (!sb.armed)
            begin
                if (pick < 10)
                    send_byte(8'($urandom()));
                else
                    send_begin(pick_size());
            end
            else if (pick < 78 && sb.len_limit == 16'd0)
                send_bad_header();
            else if (pick < 70)
                send_frame(pick_len(), 1'b0);
            else if (pick < 78)
                send_frame(pick_len(), 1'b1);
            else if (pick < 84)
                send_bad_header();
            else if (pick < 88)
                send_begin(pick_size());
            else if (pick < 94)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    do
                        b = $urandom_range(0, 255);
                    while (b == sb.magic_a);
                    send_byte(8'(b));
                end
            end
            else
            begin
                // false start: right first byte, wrong second byte
                do
                    b = $urandom_range(0, 255);
                while (b == sb.magic_b);
                send_byte(sb.magic_a);
                send_byte(8'(b));
            end
        end
        brisk = 1'b0;
    endtask

    // Receive side: random stall after each transaction, plus one long hold-off on request.
    initial
    begin
        int unsigned pause_left;
        int unsigned hold_left;
        pause_left = 0;
        hold_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                sb.match_event(result_data);
                pause_left = brisk ? 0 : $urandom_range(0, 13);
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (pause_left != 0)
            begin
                pause_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("crc_checked_chunk_deframer_top verification failed");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        reconfigure(8'hFF, 8'h00, 16'd1, 8'd0);
        send_byte(8'h5A);
        send_begin(32'd0);
        send_byte(8'h12);
        // repeated first byte, then a one-byte frame that completes an empty image
        send_byte(8'hFF);
        send_frame(16'd1, 1'b0);
        // re-arm in the middle of a header
        send_begin(32'hFFFF_FFFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_begin(32'hFFFF_FFFF);
        send_header(16'd2);
        send_begin(32'hFFFF_FFFF);
        send_header(16'd0);
        send_begin(32'hFFFF_FFFF);
        send_frame(16'd1, 1'b1);

        // fill the block while the receiver holds off
        reconfigure(8'hA5, 8'h5A, 16'd16, 8'd3);
        send_begin(32'hFFFF_FFFF);
        hold_req = 1'b1;
        send_frame(16'd12, 1'b0);
        random_stream(190);

        reconfigure(8'h00, 8'hFF, 16'hFFFF, 8'd255);
        send_begin(32'hFFFF_FFFF);
        send_header(16'hFFFF);
        repeat (3) send_byte(8'($urandom()));
        send_begin(pick_size());
        random_stream(190);

        reconfigure(8'h7E, 8'h7E, 16'd300, 8'd1);
        random_stream(190);

        reconfigure(8'h00, 8'h00, 16'd0, 8'd0);
        random_stream(40);

        repeat (2)
        begin
            reconfigure(8'($urandom()), 8'($urandom()), 16'($urandom_range(1, 64)),
                        8'($urandom_range(0, 12)));
            random_stream(190);
        end

        settle();
        repeat (8) @(posedge clk);
        if (sb.pending_events.size() != 0)
        begin
            sb.mismatches += sb.pending_events.size();
            $display("%0d expected results never arrived", sb.pending_events.size());
        end
        if (sb.mismatches == 0)
            $display("crc_checked_chunk_deframer_top verification clean");
        else
            $display("crc_checked_chunk_deframer_top verification failed");
        $finish;
    end

endmodule
